// ===== rtl/core/dga_pkg.sv =====
`default_nettype none
package dga_pkg;
  localparam int MaxLen = 32;
  localparam int Dim = MaxLen + 1;
  localparam int LenW = $clog2(MaxLen + 1);
  localparam int IdxW = $clog2(MaxLen);
  localparam int CellW = $clog2(Dim * Dim);
  localparam int CostW = 16;
  localparam int RegW = 10;
  localparam int NumRegs = 7;

  localparam logic [1:0] MODE_FIRST = 2'd0;
  localparam logic [1:0] MODE_SECOND = 2'd1;
  localparam logic [1:0] MODE_ALIGN = 2'd2;

  localparam logic [2:0] GAP_SYM = 3'd4;

  localparam logic [2:0] REG_GAP = 3'd0;
  localparam logic [2:0] REG_AC = 3'd1;
  localparam logic [2:0] REG_AG = 3'd2;
  localparam logic [2:0] REG_AT = 3'd3;
  localparam logic [2:0] REG_CG = 3'd4;
  localparam logic [2:0] REG_CT = 3'd5;
  localparam logic [2:0] REG_GT = 3'd6;

  typedef struct packed {
    logic [RegW-1:0] gap;
    logic [RegW-1:0] ac;
    logic [RegW-1:0] ag;
    logic [RegW-1:0] at;
    logic [RegW-1:0] cg;
    logic [RegW-1:0] ct;
    logic [RegW-1:0] gt;
  } costs_t;

  // symmetric substitution cost
  function automatic logic [RegW-1:0] pair_cost(input logic [1:0] a, input logic [1:0] b,
                                                input costs_t c);
    logic [1:0] lo;
    logic [1:0] hi;
    logic [RegW-1:0] r;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    r = '0;
    if (lo != hi) begin
      case ({lo, hi})
        4'b0001: r = c.ac;
        4'b0010: r = c.ag;
        4'b0011: r = c.at;
        4'b0110: r = c.cg;
        4'b0111: r = c.ct;
        default: r = c.gt;
      endcase
    end
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== rtl/core/dga_regs.sv =====
`default_nettype none
module dga_regs (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output dga_pkg::costs_t  costs
);
  logic [2:0] idx;
  logic       wr;

  assign pready = 1'b1;
  assign idx = paddr[4:2];
  assign wr = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      costs.gap <= 10'd30;
      costs.ac <= 10'd110;
      costs.ag <= 10'd48;
      costs.at <= 10'd94;
      costs.cg <= 10'd118;
      costs.ct <= 10'd48;
      costs.gt <= 10'd110;
    end else if (wr) begin
      case (idx)
        dga_pkg::REG_GAP: costs.gap <= pwdata[9:0];
        dga_pkg::REG_AC: costs.ac <= pwdata[9:0];
        dga_pkg::REG_AG: costs.ag <= pwdata[9:0];
        dga_pkg::REG_AT: costs.at <= pwdata[9:0];
        dga_pkg::REG_CG: costs.cg <= pwdata[9:0];
        dga_pkg::REG_CT: costs.ct <= pwdata[9:0];
        dga_pkg::REG_GT: costs.gt <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    case (idx)
      dga_pkg::REG_GAP: prdata[9:0] = costs.gap;
      dga_pkg::REG_AC: prdata[9:0] = costs.ac;
      dga_pkg::REG_AG: prdata[9:0] = costs.ag;
      dga_pkg::REG_AT: prdata[9:0] = costs.at;
      dga_pkg::REG_CG: prdata[9:0] = costs.cg;
      dga_pkg::REG_CT: prdata[9:0] = costs.ct;
      dga_pkg::REG_GT: prdata[9:0] = costs.gt;
      default: prdata = '0;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/core/dna_global_alignment.sv =====
`default_nettype none
// Load transactions (mode 0/1, and the ignored mode 3) give no output.
// Align: fill writes each edge cell directly and each inner cell in steps (diag, up and
// left reads, then write), the total is read, traceback walks back from (m,n) to (0,0),
// then output sends one column per item (one gap/gap item for an empty alignment), with
// m_tready stalls. The next transaction is accepted only after that. The single matrix
// RAM read port sets the pace.
// Reset (synchronous, rst high) restores register defaults and empties both
// sequences; the matrix and base stores are not cleared.
module dna_global_alignment (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [1:0] mode, [3:2] base
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [2:0] top, [5:3] bottom, [6] column_valid, [22:7] cost
  output logic             m_tlast,   // last_column
  output logic             m_tuser,   // truncated
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  localparam int LW = dga_pkg::LenW;
  localparam int CW = dga_pkg::CostW;
  localparam int AW = dga_pkg::CellW;

  localparam logic [3:0] S_IDLE = 4'd0, S_EDGE = 4'd1, S_RD_D = 4'd2, S_RD_U = 4'd3,
                         S_RD_L = 4'd4, S_WR = 4'd5, S_TB_H = 4'd6, S_TB_D = 4'd7,
                         S_TB_L = 4'd8, S_TB_U = 4'd9, S_OUT = 4'd10, S_EMPTY = 4'd11,
                         S_TOT = 4'd12, S_TB_C = 4'd13;

  dga_pkg::costs_t costs;
  dga_regs u_regs (.clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
                   .costs);

  logic [1:0] first_bases [dga_pkg::MaxLen];
  logic [1:0] second_bases [dga_pkg::MaxLen];
  logic [CW-1:0] mat [dga_pkg::Dim * dga_pkg::Dim];
  logic [5:0] col_sym [2*dga_pkg::MaxLen];

  logic [3:0] state;
  logic [LW-1:0] first_length, second_length, i, j;
  logic overflow_seen, trunc;
  logic [6:0] cols, k;
  logic [CW-1:0] acc, here, total, best, cand;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [CW-1:0] rd_data, wr_data;
  logic wr_en;
  logic [1:0] fb, sb;
  logic [dga_pkg::RegW-1:0] pc;

  wire in_acc = s_tvalid && s_tready;
  wire [1:0] mode = s_tdata[1:0];
  wire [1:0] base = s_tdata[3:2];

  assign s_tready = (state == S_IDLE);
  assign fb = first_bases[i[dga_pkg::IdxW-1:0] - 1'b1];
  assign sb = second_bases[j[dga_pkg::IdxW-1:0] - 1'b1];
  assign pc = dga_pkg::pair_cost(fb, sb, costs);

  function automatic logic [AW-1:0] addr(input logic [LW-1:0] r, input logic [LW-1:0] c);
    return AW'(r * dga_pkg::Dim + c);
  endfunction

  // matrix RAM: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) mat[wr_addr] <= wr_data;
    rd_data <= mat[rd_addr];
  end

  // RAM address and write control, and the shared adder: read cell plus the gap cost
  always_comb begin
    rd_addr = addr(i - 1'b1, j - 1'b1);
    wr_en = 1'b0;
    wr_addr = addr(i, j);
    wr_data = acc;
    cand = rd_data + CW'(costs.gap);
    best = acc;
    case (state)
      S_EDGE: begin
        wr_en = 1'b1;
      end
      S_RD_U: rd_addr = addr(i - 1'b1, j);
      S_RD_L: begin
        rd_addr = addr(i, j - 1'b1);
        if (cand < acc) best = cand;
      end
      S_WR: begin
        wr_en = 1'b1;
        if (cand < acc) wr_data = cand;
      end
      S_TB_D: rd_addr = addr(i, j - 1'b1);
      S_TOT: rd_addr = addr(i, j);
      S_TB_C: rd_addr = addr(i - 1'b1, j - 1'b1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      first_length <= '0;
      second_length <= '0;
      overflow_seen <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (mode == dga_pkg::MODE_FIRST) begin
              if (first_length < LW'(dga_pkg::MaxLen)) begin
                first_bases[first_length[dga_pkg::IdxW-1:0]] <= base;
                first_length <= first_length + 1'b1;
              end else overflow_seen <= 1'b1;
            end else if (mode == dga_pkg::MODE_SECOND) begin
              if (second_length < LW'(dga_pkg::MaxLen)) begin
                second_bases[second_length[dga_pkg::IdxW-1:0]] <= base;
                second_length <= second_length + 1'b1;
              end else overflow_seen <= 1'b1;
            end else if (mode == dga_pkg::MODE_ALIGN) begin
              trunc <= overflow_seen;
              i <= '0;
              j <= '0;
              acc <= '0;
              cols <= '0;
              state <= S_EDGE;
            end
          end
        end
        // row 0 then column 0 of each row; i,j = current cell, acc = edge value
        S_EDGE: begin
          if (i == '0 && j != second_length) begin
            j <= j + 1'b1;
            acc <= acc + CW'(costs.gap);
          end else if (i == '0) begin
            if (first_length == '0) begin
              state <= S_TOT;
            end else begin
              i <= 1'b1;
              j <= '0;
              acc <= CW'(costs.gap);
            end
          end else if (second_length == '0) begin
            if (i == first_length) state <= S_TOT;
            else begin
              i <= i + 1'b1;
              acc <= acc + CW'(costs.gap);
            end
          end else begin
            j <= 1'b1;
            state <= S_RD_D;
          end
        end
        S_RD_D: state <= S_RD_U;
        S_RD_U: begin
          acc <= rd_data + CW'(pc);
          state <= S_RD_L;
        end
        S_RD_L: begin
          acc <= best;
          state <= S_WR;
        end
        S_WR: begin
          if (j != second_length) begin
            j <= j + 1'b1;
            state <= S_RD_D;
          end else if (i != first_length) begin
            i <= i + 1'b1;
            j <= '0;
            acc <= CW'(i + 1'b1) * CW'(costs.gap);
            state <= S_EDGE;
          end else state <= S_TOT;
        end
        // read total at (m,n)
        S_TOT: begin
          i <= first_length;
          j <= second_length;
          state <= S_TB_C;
        end
        // total arrives on the first pass only; later passes just reissue the diag read
        S_TB_C: begin
          if (cols == '0) begin
            total <= rd_data;
            here <= rd_data;
          end
          state <= S_TB_H;
        end
        // traceback step at (i,j); diag read in flight
        S_TB_H: begin
          if (i == '0 && j == '0) begin
            k <= cols;
            state <= (cols == '0) ? S_EMPTY : S_OUT;
          end else if (j == '0) begin
            col_sym[cols[5:0]] <= {dga_pkg::GAP_SYM, 1'b0, fb};
            cols <= cols + 1'b1;
            i <= i - 1'b1;
          end else if (i == '0) begin
            col_sym[cols[5:0]] <= {1'b0, sb, dga_pkg::GAP_SYM};
            cols <= cols + 1'b1;
            j <= j - 1'b1;
          end else state <= S_TB_D;
        end
        S_TB_D: begin
          if (rd_data + CW'(pc) == here) begin
            col_sym[cols[5:0]] <= {1'b0, sb, 1'b0, fb};
            cols <= cols + 1'b1;
            i <= i - 1'b1;
            j <= j - 1'b1;
            here <= rd_data;
            state <= S_TB_U;
          end else state <= S_TB_L;
        end
        S_TB_L: begin
          if (rd_data + CW'(costs.gap) == here) begin
            col_sym[cols[5:0]] <= {1'b0, sb, dga_pkg::GAP_SYM};
            j <= j - 1'b1;
            here <= rd_data;
          end else begin
            col_sym[cols[5:0]] <= {dga_pkg::GAP_SYM, 1'b0, fb};
            i <= i - 1'b1;
            here <= here - CW'(costs.gap);
          end
          cols <= cols + 1'b1;
          state <= S_TB_C;
        end
        S_TB_U: state <= S_TB_C;
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            if (k == '0) begin
              m_tvalid <= 1'b0;
              first_length <= '0;
              second_length <= '0;
              overflow_seen <= 1'b0;
              state <= S_IDLE;
            end else begin
              m_tvalid <= 1'b1;
              m_tdata <= {1'b0, total, 1'b1, col_sym[6'(k - 1'b1)]};
              m_tlast <= (k == 7'd1);
              m_tuser <= trunc;
              k <= k - 1'b1;
            end
          end
        end
        S_EMPTY: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata <= {1'b0, total, 1'b0, dga_pkg::GAP_SYM, dga_pkg::GAP_SYM};
            m_tlast <= 1'b1;
            m_tuser <= trunc;
            k <= '0;
            state <= S_OUT;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !s_tready) else $error("accepting while busy");
  a_len: assert property (@(posedge clk) disable iff (rst)
    first_length <= LW'(dga_pkg::MaxLen)) else $error("length overflow");
  a_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast && m_tready) |=> (state == S_OUT || state == S_IDLE))
    else $error("bad end of run");
`endif
endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
`default_nettype none
module testbench;
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;     // [1:0] mode, [3:2] base
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;          // [2:0] top, [5:3] bottom, [6] column_valid, [22:7] cost
  logic        m_tlast;          // last_column
  logic        m_tuser;          // truncated
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  dna_global_alignment dut (.*);

  always #2 clk = ~clk;

  typedef struct packed {
    logic [2:0]  top;
    logic [2:0]  bottom;
    logic        col_valid;
    logic        last;
    logic [15:0] cost;
    logic        trunc;
  } column_t;

  // aligner shadow state
  logic [dga_pkg::RegW-1:0] cfg [dga_pkg::NumRegs];
  logic [1:0]      seq_a [dga_pkg::MaxLen];
  logic [1:0]      seq_b [dga_pkg::MaxLen];
  int              len_a, len_b;
  logic            dropped;
  int              score [dga_pkg::Dim][dga_pkg::Dim];
  column_t         pending_cols [$];

  int  errors = 0;
  int  cycles = 0;
  bit  stall_hold = 1'b0;
  bit  rx_noidle = 1'b0;
  bit  tx_noidle = 1'b0;

  function automatic int sub_cost(logic [1:0] a, logic [1:0] b);
    logic [1:0] lo, hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (lo == hi) return 0;
    if (lo == 2'd0)
      return hi == 2'd1 ? cfg[dga_pkg::REG_AC]
                        : (hi == 2'd2 ? cfg[dga_pkg::REG_AG] : cfg[dga_pkg::REG_AT]);
    if (lo == 2'd1) return hi == 2'd2 ? cfg[dga_pkg::REG_CG] : cfg[dga_pkg::REG_CT];
    return cfg[dga_pkg::REG_GT];
  endfunction

  // predict the columns produced by one transaction
  task automatic predict_item(logic [1:0] mode, logic [1:0] base);
    int i, j, total, g, ncol;
    column_t c;
    column_t rev [$];
    g = cfg[dga_pkg::REG_GAP];
    if (mode == dga_pkg::MODE_FIRST || mode == dga_pkg::MODE_SECOND) begin
      if (mode == dga_pkg::MODE_FIRST) begin
        if (len_a < dga_pkg::MaxLen) begin
          seq_a[len_a] = base; len_a++;
        end else dropped = 1'b1;
      end else begin
        if (len_b < dga_pkg::MaxLen) begin
          seq_b[len_b] = base; len_b++;
        end else dropped = 1'b1;
      end
      return;
    end
    if (mode != dga_pkg::MODE_ALIGN) return;
    for (i = 0; i <= len_a; i++) score[i][0] = i * g;
    for (j = 0; j <= len_b; j++) score[0][j] = j * g;
    for (i = 1; i <= len_a; i++)
      for (j = 1; j <= len_b; j++) begin
        int d, u, l;
        d = score[i-1][j-1] + sub_cost(seq_a[i-1], seq_b[j-1]);
        u = score[i-1][j] + g;
        l = score[i][j-1] + g;
        if (u < d) d = u;
        if (l < d) d = l;
        score[i][j] = d & 16'hFFFF;
      end
    total = score[len_a][len_b];
    i = len_a;
    j = len_b;
    c = '0;
    c.col_valid = 1'b1;
    while (i != 0 || j != 0) begin
      if (i != 0 && j != 0 &&
          score[i-1][j-1] + sub_cost(seq_a[i-1], seq_b[j-1]) == score[i][j]) begin
        c.top = seq_a[i-1]; c.bottom = seq_b[j-1]; i--; j--;
      end else if (j != 0 && (i == 0 || score[i][j-1] + g == score[i][j])) begin
        c.top = dga_pkg::GAP_SYM; c.bottom = seq_b[j-1]; j--;
      end else begin
        c.top = seq_a[i-1]; c.bottom = dga_pkg::GAP_SYM; i--;
      end
      rev.push_front(c);
    end
    ncol = rev.size();
    if (ncol == 0) begin
      c = '{dga_pkg::GAP_SYM, dga_pkg::GAP_SYM, 1'b0, 1'b1, total[15:0], dropped};
      pending_cols.push_back(c);
    end else begin
      for (int k = 0; k < ncol; k++) begin
        c = rev[k];
        c.last = (k == ncol - 1);
        c.cost = total[15:0];
        c.trunc = dropped;
        pending_cols.push_back(c);
      end
    end
    len_a = 0;
    len_b = 0;
    dropped = 1'b0;
  endtask

  // send one transaction, with random idling; tvalid stays high for a following one
  task automatic send_item(logic [1:0] mode, logic [1:0] base);
    while (!tx_noidle && $urandom_range(99) < 15) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'd0, base, mode};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_item(mode, base);
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (pending_cols.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [dga_pkg::RegW-1:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= {22'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    cfg[idx] = val;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_seq(int na, int nb, bit rnd, logic [1:0] fixed);
    for (int k = 0; k < na; k++) send_item(dga_pkg::MODE_FIRST, rnd ? 2'($urandom) : fixed);
    for (int k = 0; k < nb; k++) send_item(dga_pkg::MODE_SECOND, rnd ? 2'($urandom) : fixed);
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      column_t got, want;
      got = '{m_tdata[2:0], m_tdata[5:3], m_tdata[6], m_tlast, m_tdata[22:7], m_tuser};
      if (pending_cols.size() == 0) begin
        $display("%0t: unexpected column %h", $time, got);
        errors++;
      end else begin
        want = pending_cols.pop_front();
        if (got !== want) begin
          $display("%0t: column mismatch expected %h actual %h", $time, want, got);
          errors++;
        end
      end
    end
  end

  // receiver: random backpressure plus one long hold-off
  always @(posedge clk) begin
    if (stall_hold) m_tready <= 1'b0;
    else m_tready <= rx_noidle || ($urandom_range(99) >= 15);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("dna_global_alignment test failed");
      $finish;
    end
  end

  // directed rows: mode, base, count
  typedef struct {
    logic [1:0] mode;
    logic [1:0] base;
    int         count;
  } row_t;

  row_t plan [] = '{
    '{dga_pkg::MODE_ALIGN, 2'd0, 1},            // both empty
    '{dga_pkg::MODE_FIRST, 2'd3, 1}, '{dga_pkg::MODE_ALIGN, 2'd1, 1},  // one side only
    '{dga_pkg::MODE_SECOND, 2'd2, 2}, '{dga_pkg::MODE_ALIGN, 2'd3, 1},
    '{dga_pkg::MODE_FIRST, 2'd0, 1}, '{dga_pkg::MODE_FIRST, 2'd1, 1},
    '{dga_pkg::MODE_SECOND, 2'd2, 1}, '{dga_pkg::MODE_SECOND, 2'd3, 1},
    '{2'd3, 2'd3, 1}, '{dga_pkg::MODE_ALIGN, 2'd0, 1},
    '{dga_pkg::MODE_FIRST, 2'd1, 33}, '{dga_pkg::MODE_SECOND, 2'd2, 2},  // full store
    '{dga_pkg::MODE_ALIGN, 2'd0, 1},
    '{dga_pkg::MODE_ALIGN, 2'd0, 1}
  };

  initial begin
    cfg = '{10'd30, 10'd110, 10'd48, 10'd94, 10'd118, 10'd48, 10'd110};
    len_a = 0; len_b = 0; dropped = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part; empty alignment known at a glance
    foreach (plan[r]) begin
      for (int k = 0; k < plan[r].count; k++) send_item(plan[r].mode, plan[r].base);
      if (r == 0 && pending_cols[0] !==
          column_t'{dga_pkg::GAP_SYM, dga_pkg::GAP_SYM, 1'b0, 1'b1, 16'd0, 1'b0}) begin
        $display("%0t: empty alignment expected %h actual %h", $time,
                 column_t'{dga_pkg::GAP_SYM, dga_pkg::GAP_SYM, 1'b0, 1'b1, 16'd0, 1'b0},
                 pending_cols[0]);
        errors++;
      end
    end
    wait_drain();

    // extreme costs
    for (int r = 0; r < dga_pkg::NumRegs; r++) write_reg(r[2:0], 10'h3FF);
    load_seq(32, 32, 1, 2'd0);
    send_item(dga_pkg::MODE_ALIGN, 2'd0);
    wait_drain();
    for (int r = 0; r < dga_pkg::NumRegs; r++) write_reg(r[2:0], 10'd0);
    load_seq(5, 7, 1, 2'd0);
    send_item(dga_pkg::MODE_ALIGN, 2'd2);
    wait_drain();

    // long receiver hold-off while sender keeps loading and aligning
    write_reg(dga_pkg::REG_GAP, 10'd7);
    for (int r = 1; r < dga_pkg::NumRegs; r++) write_reg(r[2:0], 10'($urandom_range(20)));
    fork
      begin
        stall_hold = 1'b1;
        repeat (3000) @(posedge clk);
        stall_hold = 1'b0;
      end
      begin
        repeat (3) begin
          load_seq(4, 3, 1, 2'd0);
          send_item(dga_pkg::MODE_ALIGN, 2'd0);
        end
        wait_drain();
      end
    join
    wait_drain();

    // random phases
    for (int ph = 0; ph < 4; ph++) begin
      for (int r = 0; r < dga_pkg::NumRegs; r++) write_reg(r[2:0], 10'($urandom_range(1023)));
      if (ph == 3) write_reg(dga_pkg::REG_GAP, 10'($urandom_range(3)));
      rx_noidle = (ph == 2);
      tx_noidle = (ph == 2);
      repeat (2) begin
        int sel;
        sel = $urandom_range(9);
        if (sel == 0) begin
          send_item(2'($urandom), 2'($urandom));    // noise
        end else begin
          int na, nb;
          na = (sel == 1) ? 32 + $urandom_range(2) : $urandom_range(4);
          nb = (sel == 2) ? 32 + $urandom_range(2) : $urandom_range(4);
          load_seq(na, nb, 1, 2'd0);
          if ($urandom_range(3) == 0) send_item(2'd3, 2'($urandom));
          send_item(dga_pkg::MODE_ALIGN, 2'($urandom));
        end
      end
      wait_drain();
    end
    rx_noidle = 1'b0;
    tx_noidle = 1'b0;

    wait_drain();
    if (errors == 0) begin
      $display("dna_global_alignment test passed");
    end else begin
      $display("dna_global_alignment test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
rtl/core/dga_pkg.sv
rtl/core/dga_regs.sv
rtl/core/dna_global_alignment.sv
sim/testbench.sv
